>>> rtl/core/weighted_table_mix_interpolator_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef WEIGHTED_TABLE_MIX_INTERPOLATOR_ASSERT_SVH
`define WEIGHTED_TABLE_MIX_INTERPOLATOR_ASSERT_SVH

`define WTMI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define WTMI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/wtmi_pkg.sv
`default_nettype none
package wtmi_pkg;

  localparam int DEF_MAX_LANES   = 64;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int IDX_W           = 13;
  localparam int OUT_W           = 25;
  localparam int CNT_W           = 7;
  localparam int Q_DEPTH         = 4;
  localparam logic [CNT_W-1:0] LANE_COUNT_RESET = 7'd13;
  localparam logic [OUT_W-1:0] OUT_MAX          = 25'h0FFFFFF;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_ENABLE = 2'd2,
    OP_EVAL   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_RUN,
    ST_DRAIN,
    ST_MLO,
    ST_MHI,
    ST_FIN
  } bk_state_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         lane;
    logic [IDX_W-1:0]   idx0;
    logic [IDX_W-1:0]   idx1;
    logic [15:0]        frac;
    logic [15:0]        value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> rtl/core/wtmi_if.sv
`default_nettype none
interface wtmi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [5:0]         lane_index;
  logic [9:0]         sample_index;
  logic signed [15:0] sample_value;
  logic signed [15:0] amplitude;
  logic               enable;
  logic signed [15:0] position;

  modport source (output valid, opcode, lane_index, sample_index, sample_value,
                  amplitude, enable, position, input ready);
  modport sink (input valid, opcode, lane_index, sample_index, sample_value,
                amplitude, enable, position, output ready);
endinterface

interface wtmi_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] mixed_value;

  modport source (output valid, mixed_value, input ready);
  modport sink (input valid, mixed_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/wtmi_front.sv
`default_nettype none
module wtmi_front #(
  parameter int MAX_LANE_SLOTS = wtmi_pkg::DEF_MAX_LANES,
  parameter int TABLE_DEPTH    = wtmi_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  wtmi_in_if.sink                         in_ch,
  input  wire logic                       cfg_we,
  input  wire logic [wtmi_pkg::CNT_W-1:0] cfg_wdata,
  input  wire wtmi_pkg::q_status_t        q_stat,
  output wtmi_pkg::cmd_t                  q_din,
  output logic                            q_push,
  output logic [wtmi_pkg::CNT_W-1:0]      lanes_used
);

  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int PW = 16 + TW;
  localparam logic [TW-1:0] LAST = TW'(TABLE_DEPTH - 1);

  logic [wtmi_pkg::CNT_W-1:0] lane_count_r;
  logic [15:0]                u;
  logic [PW-1:0]              p;
  logic [TW-1:0]              i0;
  logic [TW-1:0]              i1;
  logic                       lane_ok;
  logic                       keep;
  wtmi_pkg::op_t              op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_count_r <= wtmi_pkg::LANE_COUNT_RESET;
    end else if (cfg_we) begin
      lane_count_r <= cfg_wdata;
    end
  end

  assign lanes_used = (32'(lane_count_r) > 32'(MAX_LANE_SLOTS)) ?
                      wtmi_pkg::CNT_W'(MAX_LANE_SLOTS) : lane_count_r;

  always_comb begin
    op = wtmi_pkg::op_t'(in_ch.opcode);
    u  = {~in_ch.position[15], in_ch.position[14:0]};
    p  = PW'(u) * PW'(TABLE_DEPTH - 1);
    i0 = (p[PW-1:16] > LAST) ? LAST : p[PW-1:16];
    i1 = (i0 == LAST) ? LAST : i0 + TW'(1);
    lane_ok = {1'b0, in_ch.lane_index} < lanes_used;
    case (op)
      wtmi_pkg::OP_SAMPLE: keep = lane_ok &&
                           (32'(in_ch.sample_index) < 32'(TABLE_DEPTH));
      wtmi_pkg::OP_WEIGHT: keep = lane_ok;
      wtmi_pkg::OP_ENABLE: keep = lane_ok;
      default:             keep = 1'b1;
    endcase
    q_din.op   = op;
    q_din.lane = in_ch.lane_index;
    q_din.frac = p[15:0];
    if (op == wtmi_pkg::OP_SAMPLE) begin
      q_din.idx0 = wtmi_pkg::IDX_W'(in_ch.sample_index);
    end else begin
      q_din.idx0 = wtmi_pkg::IDX_W'(i0);
    end
    q_din.idx1 = wtmi_pkg::IDX_W'(i1);
    case (op)
      wtmi_pkg::OP_SAMPLE: q_din.value = in_ch.sample_value;
      wtmi_pkg::OP_WEIGHT: q_din.value = in_ch.amplitude;
      wtmi_pkg::OP_ENABLE: q_din.value = {15'd0, in_ch.enable};
      default:             q_din.value = 16'd0;
    endcase
  end

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full && keep;

endmodule
`default_nettype wire

>>> rtl/core/wtmi_queue.sv
`default_nettype none
module wtmi_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire wtmi_pkg::cmd_t  din,
  input  wire logic            pop,
  output wtmi_pkg::cmd_t       dout,
  output wtmi_pkg::q_status_t  stat
);

  localparam int PTR_W = $clog2(wtmi_pkg::Q_DEPTH);

  wtmi_pkg::cmd_t   slot_r [wtmi_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= din;
    end
  end

  assign dout       = slot_r[rd_r];
  assign stat.full  = cnt_r == (PTR_W+1)'(wtmi_pkg::Q_DEPTH);
  assign stat.empty = cnt_r == '0;

endmodule
`default_nettype wire

>>> rtl/core/wtmi_back.sv
`default_nettype none
module wtmi_back #(
  parameter int MAX_LANE_SLOTS = wtmi_pkg::DEF_MAX_LANES,
  parameter int TABLE_DEPTH    = wtmi_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire wtmi_pkg::cmd_t             q_dout,
  input  wire wtmi_pkg::q_status_t        q_stat,
  input  wire logic [wtmi_pkg::CNT_W-1:0] lanes_used,
  output logic                            q_pop,
  wtmi_out_if.source                      out_ch
);

  localparam int LW = (MAX_LANE_SLOTS > 1) ? $clog2(MAX_LANE_SLOTS) : 1;
  localparam int CW = $clog2(MAX_LANE_SLOTS + 1);
  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int AW = 33 + LW;
  localparam int HW = AW - 15 + 17;
  localparam int RW = AW + 19;

  wtmi_pkg::bk_state_t st_r, st_nxt;
  wtmi_pkg::cmd_t      cmd_r;

  logic signed [15:0] tab_mem [2**(LW+TW)];
  logic signed [15:0] wgt_mem [2**LW];
  logic [MAX_LANE_SLOTS-1:0] wv_r;
  logic [MAX_LANE_SLOTS-1:0] en_r;

  logic [CW-1:0]       k_r;
  logic                issue, load;
  logic                v1_r, v2_r, keep_r;
  logic signed [15:0]  md0_r, md1_r, wd_r;
  logic signed [31:0]  pr0_r, pr1_r;
  logic signed [AW-1:0] acc0_r, acc1_r;
  logic signed [AW:0]   diff;
  logic [31:0]          lo_r;
  logic signed [HW-1:0] hi_r;
  logic signed [RW-1:0] r_sum, r_sh;
  logic                 sat;
  logic                 ov_r;
  logic [wtmi_pkg::OUT_W-1:0] od_r;
  logic [LW-1:0]        k_lane;
  logic [LW-1:0]        w_lane;

  assign k_lane = k_r[LW-1:0];
  assign w_lane = cmd_r.lane[LW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wtmi_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    issue  = 1'b0;
    load   = 1'b0;
    case (st_r)
      wtmi_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop  = 1'b1;
          st_nxt = wtmi_pkg::ST_DISP;
        end
      end
      wtmi_pkg::ST_DISP: begin
        if (cmd_r.op == wtmi_pkg::OP_EVAL) begin
          st_nxt = wtmi_pkg::ST_RUN;
        end else begin
          st_nxt = wtmi_pkg::ST_IDLE;
        end
      end
      wtmi_pkg::ST_RUN: begin
        if (wtmi_pkg::CNT_W'(k_r) < lanes_used) begin
          issue = 1'b1;
        end else begin
          st_nxt = wtmi_pkg::ST_DRAIN;
        end
      end
      wtmi_pkg::ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          st_nxt = wtmi_pkg::ST_MLO;
        end
      end
      wtmi_pkg::ST_MLO: st_nxt = wtmi_pkg::ST_MHI;
      wtmi_pkg::ST_MHI: st_nxt = wtmi_pkg::ST_FIN;
      wtmi_pkg::ST_FIN: begin
        if (!ov_r || out_ch.ready) begin
          load   = 1'b1;
          st_nxt = wtmi_pkg::ST_IDLE;
        end
      end
      default: st_nxt = wtmi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_dout;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == wtmi_pkg::ST_DISP && cmd_r.op == wtmi_pkg::OP_SAMPLE) begin
      tab_mem[{w_lane, cmd_r.idx0[TW-1:0]}] <= cmd_r.value;
    end
    md0_r <= tab_mem[{k_lane, cmd_r.idx0[TW-1:0]}];
    md1_r <= tab_mem[{k_lane, cmd_r.idx1[TW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (st_r == wtmi_pkg::ST_DISP && cmd_r.op == wtmi_pkg::OP_WEIGHT) begin
      wgt_mem[w_lane] <= cmd_r.value;
    end
    wd_r <= wgt_mem[k_lane];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
      en_r <= '0;
    end else if (st_r == wtmi_pkg::ST_DISP) begin
      if (cmd_r.op == wtmi_pkg::OP_WEIGHT) begin
        wv_r[w_lane] <= 1'b1;
      end
      if (cmd_r.op == wtmi_pkg::OP_ENABLE) begin
        en_r[w_lane] <= cmd_r.value[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (st_r == wtmi_pkg::ST_DISP) begin
        k_r <= '0;
      end else if (issue) begin
        k_r <= k_r + CW'(1);
      end
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    keep_r <= en_r[k_lane] && wv_r[k_lane];
    if (v1_r) begin
      pr0_r <= keep_r ? wd_r * md0_r : 32'sd0;
      pr1_r <= keep_r ? wd_r * md1_r : 32'sd0;
    end
    if (st_r == wtmi_pkg::ST_DISP) begin
      acc0_r <= '0;
      acc1_r <= '0;
    end else if (v2_r) begin
      acc0_r <= acc0_r + AW'(pr0_r);
      acc1_r <= acc1_r + AW'(pr1_r);
    end
  end

  assign diff = (AW+1)'(acc1_r) - (AW+1)'(acc0_r);

  always_ff @(posedge clk) begin
    if (st_r == wtmi_pkg::ST_MLO) begin
      lo_r <= 32'(cmd_r.frac) * 32'(diff[15:0]);
    end
    if (st_r == wtmi_pkg::ST_MHI) begin
      hi_r <= HW'($signed({1'b0, cmd_r.frac})) * HW'($signed(diff[AW:16]));
    end
  end

  always_comb begin
    r_sum = (RW'(acc0_r) <<< 16) + (RW'(hi_r) <<< 16) + RW'($signed({1'b0, lo_r}));
    r_sh  = r_sum >>> 29;
    sat   = !r_sh[RW-1] && (|r_sh[RW-2:wtmi_pkg::OUT_W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      od_r <= sat ? wtmi_pkg::OUT_MAX : r_sh[wtmi_pkg::OUT_W-1:0];
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.mixed_value = od_r;

endmodule
`default_nettype wire

>>> rtl/core/weighted_table_mix_interpolator.sv
// Channel | Dir | Handshake     | Contents
// in_ch   | in  | valid / ready | opcode, lane, sample index and value, amplitude, enable, position
// out_ch  | out | valid / ready | mixed_value (Q9.15)
// cfg     | in  | write enable  | lane_count
// In the back end a write passes the idle and dispatch states; an evaluate also runs a lane walk
// over lane_count lanes (capped at MAX_LANE_SLOTS), reading one lane per cycle, before interpolating.
// The front end queues up to four transactions, so input keeps flowing while the back end works.
// Reset is synchronous and active low; it clears weight-valid flags and enables, not the curve table.
// A stalled output holds the back end in its final step; the queue then fills and drops ready.
`default_nettype none
`include "weighted_table_mix_interpolator_assert.svh"
module weighted_table_mix_interpolator #(
  parameter int MAX_LANE_SLOTS = wtmi_pkg::DEF_MAX_LANES,
  parameter int TABLE_DEPTH    = wtmi_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  wtmi_in_if.sink                         in_ch,
  wtmi_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [wtmi_pkg::CNT_W-1:0] cfg_wdata
);

  wtmi_pkg::cmd_t             q_din;
  wtmi_pkg::cmd_t             q_dout;
  wtmi_pkg::q_status_t        q_stat;
  logic                       q_push;
  logic                       q_pop;
  logic [wtmi_pkg::CNT_W-1:0] lanes_used;

  wtmi_front #(
    .MAX_LANE_SLOTS(MAX_LANE_SLOTS),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_stat(q_stat),
    .q_din(q_din),
    .q_push(q_push),
    .lanes_used(lanes_used)
  );

  wtmi_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .din(q_din),
    .pop(q_pop),
    .dout(q_dout),
    .stat(q_stat)
  );

  wtmi_back #(
    .MAX_LANE_SLOTS(MAX_LANE_SLOTS),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_dout(q_dout),
    .q_stat(q_stat),
    .lanes_used(lanes_used),
    .q_pop(q_pop),
    .out_ch(out_ch)
  );

  `WTMI_ASSERT_IMP(a_no_overflow, clk, rst_n, q_stat.full, !q_push)
  `WTMI_ASSERT_IMP(a_no_underflow, clk, rst_n, q_stat.empty, !q_pop)
  `WTMI_ASSERT_NXT(a_push_fills, clk, rst_n, q_push, !q_stat.empty)

endmodule
`default_nettype wire
